/* src/fcse_pkg.sv */
// Package for the flow counter slot engine: field widths, word layouts,
// operation and status codes, state encoding and the counter pair type.
// No dependencies; every other file of the block imports it.
package fcse_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEF_NUM_SLOTS   = 4096;
   localparam int DEF_NUM_WRITERS = 4;

   // Field widths of the request and response words.
   localparam int KIND_W         = 3;
   localparam int SLOT_FIELD_W   = 12;
   localparam int WRITER_FIELD_W = 2;
   localparam int PINC_W         = 16;
   localparam int BINC_W         = 32;
   localparam int TOTAL_W        = 64;
   localparam int STATUS_W       = 2;

   // Request word layout, lowest field first.
   localparam int REQ_SLOT_LSB   = 0;
   localparam int REQ_WRITER_LSB = REQ_SLOT_LSB + SLOT_FIELD_W;
   localparam int REQ_PINC_LSB   = REQ_WRITER_LSB + WRITER_FIELD_W;
   localparam int REQ_BINC_LSB   = REQ_PINC_LSB + PINC_W;
   localparam int REQ_DATA_W     = 64;

   // Response word layout, lowest field first.
   localparam int RSP_GRANT_LSB  = 0;
   localparam int RSP_PTOT_LSB   = RSP_GRANT_LSB + SLOT_FIELD_W;
   localparam int RSP_BTOT_LSB   = RSP_PTOT_LSB + TOTAL_W;
   localparam int RSP_STATUS_LSB = RSP_BTOT_LSB + TOTAL_W;
   localparam int RSP_DATA_W     = 144;

   // Operation codes carried in the request tuser.
   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 3'd0,
      KIND_FREE  = 3'd1,
      KIND_INC   = 3'd2,
      KIND_GET   = 3'd3,
      KIND_CLEAR = 3'd4
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Commands to the free-slot stack.
   typedef enum logic [1:0] {
      STK_NONE,
      STK_PUSH,
      STK_POP
   } stk_op_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_RESP
   } state_type;

   // One writer's counter pair as stored in the counter memory.
   typedef struct packed {
      logic [TOTAL_W-1:0] bytes_cnt;
      logic [TOTAL_W-1:0] pkts_cnt;
   } pair_type;

endpackage

/* src/fcse_free_stack.sv */
// Free-slot stack of the flow counter slot engine: one synchronous memory
// with a fill count and a low-water mark that stands in for its reset image.
// Depends on fcse_pkg.
module fcse_free_stack
   import fcse_pkg::*;
#(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   localparam int SLOT_W = $clog2(NUM_SLOTS),
   localparam int CNT_W = $clog2(NUM_SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  stk_op_type        op,
   input  logic [SLOT_W-1:0] push_slot,
   output logic [CNT_W-1:0]  count,
   output logic [SLOT_W-1:0] pop_slot
);

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(NUM_SLOTS);

   logic [SLOT_W-1:0] slot_mem [NUM_SLOTS];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  low_ff, low_in;
   logic [CNT_W-1:0]  top_idx;
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0] rd_q_ff;
   logic              rd_written_ff, rd_written_in;

   // Stack pointer and low-water mark. Every entry at or above the lowest
   // index ever pushed has been written since the pointer last stood there;
   // entries below it still hold their reset image.
   always_comb begin
      top_idx       = count_ff - CNT_W'(1);
      count_in      = count_ff;
      low_in        = low_ff;
      rd_idx_in     = rd_idx_ff;
      rd_written_in = rd_written_ff;
      case (op)
         STK_PUSH: begin
            count_in = count_ff + CNT_W'(1);
            if (count_ff < low_ff) begin
               low_in = count_ff;
            end
         end
         STK_POP: begin
            count_in      = top_idx;
            rd_idx_in     = top_idx[SLOT_W-1:0];
            rd_written_in = (top_idx >= low_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= FULL_COUNT;
         low_ff   <= FULL_COUNT;
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
      end
   end

   // Stack memory: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (op == STK_PUSH) begin
         slot_mem[count_ff[SLOT_W-1:0]] <= push_slot;
      end
      if (op == STK_POP) begin
         rd_q_ff <= slot_mem[rd_idx_in];
      end
      rd_idx_ff     <= rd_idx_in;
      rd_written_ff <= rd_written_in;
   end

   // An entry never pushed reads as its reset value, which puts slot 0 on top.
   assign pop_slot = rd_written_ff ? rd_q_ff : (LAST_SLOT - rd_idx_ff);
   assign count    = count_ff;

endmodule

/* src/flow_counter_slot_engine.sv */
// Flow counter slot engine: per-slot, per-writer packet and byte counters, slots
// handed out from a free-slot stack (fcse_free_stack); depends on fcse_pkg.
// Free, clear and refused items go from idle straight to the result state, which
// registers the result word; allocate and increment pass through a read state, and get
// also through a summing state. One item is in work at a time. Synchronous reset, then
// a clearing pass over every slot row with req_tready low.
module flow_counter_slot_engine
   import fcse_pkg::*;
#(
   parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
   parameter int NUM_WRITERS = DEF_NUM_WRITERS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // slot[11:0], writer[13:12], packet_increment[29:14],
   // byte_increment[61:30], zero[63:62]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[2:0]
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // granted_slot[11:0], packet_total[75:12], byte_total[139:76],
   // status[141:140], zero[143:142]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int WR_W   = (NUM_WRITERS > 1) ? $clog2(NUM_WRITERS) : 1;

   localparam logic [SLOT_W-1:0] ROW_LAST   = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [WR_W-1:0]   W_LAST     = WR_W'(NUM_WRITERS - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(NUM_SLOTS);

   // Request fields.
   kind_type                  req_kind;
   logic [SLOT_FIELD_W-1:0]   req_slot;
   logic [WRITER_FIELD_W-1:0] req_writer;
   logic [PINC_W-1:0]         req_pinc;
   logic [BINC_W-1:0]         req_binc;
   logic                      accept;
   logic                      slot_ok;
   logic                      writer_ok;
   logic                      out_free;

   // Sequencer and item registers.
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  clr_row_ff, clr_row_in;
   kind_type           kind_ff, kind_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [WR_W-1:0]    lane_ff, lane_in;
   logic [PINC_W-1:0]  pinc_ff, pinc_in;
   logic [BINC_W-1:0]  binc_ff, binc_in;
   logic [WR_W-1:0]    wcnt_ff, wcnt_in;

   // Result registers.
   logic [SLOT_FIELD_W-1:0] res_granted_ff, res_granted_in;
   status_type              res_status_ff, res_status_in;
   logic [TOTAL_W-1:0]      acc_pkt_ff, acc_pkt_in;
   logic [TOTAL_W-1:0]      acc_byte_ff, acc_byte_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   // Free-slot stack.
   stk_op_type        stk_op;
   logic [CNT_W-1:0]  stk_count;
   logic [SLOT_W-1:0] stk_pop_slot;
   logic              stk_empty;
   logic              stk_full;

   // Counter memory: one row per slot, one pair per writer in each row.
   pair_type [NUM_WRITERS-1:0] ctr_mem [NUM_SLOTS];
   pair_type [NUM_WRITERS-1:0] ctr_q_ff;
   logic                       ctr_rd_en;
   logic [SLOT_W-1:0]          ctr_rd_addr;
   logic [NUM_WRITERS-1:0]     ctr_wr_en;
   logic [SLOT_W-1:0]          ctr_wr_addr;
   pair_type                   ctr_wr_data;

   // Field extraction and item checks.
   assign req_kind   = kind_type'(req_tuser);
   assign req_slot   = req_tdata[REQ_SLOT_LSB +: SLOT_FIELD_W];
   assign req_writer = req_tdata[REQ_WRITER_LSB +: WRITER_FIELD_W];
   assign req_pinc   = req_tdata[REQ_PINC_LSB +: PINC_W];
   assign req_binc   = req_tdata[REQ_BINC_LSB +: BINC_W];
   assign accept     = req_tvalid && req_tready;
   assign slot_ok    = int'(req_slot) < NUM_SLOTS;
   assign writer_ok  = int'(req_writer) < NUM_WRITERS;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stk_empty  = (stk_count == '0);
   assign stk_full   = (stk_count == FULL_COUNT);

   fcse_free_stack #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .op        (stk_op),
      .push_slot (SLOT_W'(req_slot)),
      .count     (stk_count),
      .pop_slot  (stk_pop_slot)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == ROW_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_ALLOC: state_in = stk_empty ? ST_RESP : ST_READ;
                  KIND_INC:   state_in = (slot_ok && writer_ok) ? ST_READ : ST_RESP;
                  KIND_GET:   state_in = slot_ok ? ST_READ : ST_RESP;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_READ: begin
            state_in = (kind_ff == KIND_GET) ? ST_SUM : ST_RESP;
         end
         ST_SUM: begin
            if (wcnt_ff == W_LAST) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Sequencer outputs: memory accesses, stack commands and result updates.
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      stk_op         = STK_NONE;
      ctr_rd_en      = accept;
      ctr_rd_addr    = SLOT_W'(req_slot);
      ctr_wr_en      = '0;
      ctr_wr_addr    = slot_ff;
      ctr_wr_data    = '0;
      clr_row_in     = clr_row_ff;
      kind_in        = kind_ff;
      slot_in        = slot_ff;
      lane_in        = lane_ff;
      pinc_in        = pinc_ff;
      binc_in        = binc_ff;
      wcnt_in        = wcnt_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      acc_pkt_in     = acc_pkt_ff;
      acc_byte_in    = acc_byte_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;
      case (state_ff)
         ST_CLEAR: begin
            // Zero one slot row per cycle after reset.
            ctr_wr_en   = '1;
            ctr_wr_addr = clr_row_ff;
            clr_row_in  = clr_row_ff + SLOT_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in        = req_kind;
               slot_in        = SLOT_W'(req_slot);
               lane_in        = WR_W'(req_writer);
               pinc_in        = req_pinc;
               binc_in        = req_binc;
               wcnt_in        = '0;
               res_granted_in = '0;
               res_status_in  = STATUS_OK;
               acc_pkt_in     = '0;
               acc_byte_in    = '0;
               case (req_kind)
                  KIND_ALLOC: begin
                     if (stk_empty) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        stk_op = STK_POP;
                     end
                  end
                  KIND_FREE: begin
                     if (stk_full) begin
                        res_status_in = STATUS_FULL;
                     end else if (slot_ok) begin
                        stk_op = STK_PUSH;
                     end
                  end
                  KIND_CLEAR: begin
                     if (slot_ok) begin
                        ctr_wr_en   = '1;
                        ctr_wr_addr = SLOT_W'(req_slot);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            case (kind_ff)
               KIND_ALLOC: begin
                  // The popped slot starts from zero in every writer.
                  ctr_wr_en      = '1;
                  ctr_wr_addr    = stk_pop_slot;
                  res_granted_in = SLOT_FIELD_W'(stk_pop_slot);
               end
               KIND_INC: begin
                  ctr_wr_en[lane_ff]    = 1'b1;
                  ctr_wr_data.pkts_cnt  = ctr_q_ff[lane_ff].pkts_cnt + TOTAL_W'(pinc_ff);
                  ctr_wr_data.bytes_cnt = ctr_q_ff[lane_ff].bytes_cnt + TOTAL_W'(binc_ff);
               end
               default: begin
               end
            endcase
         end
         ST_SUM: begin
            // Add one writer's pair per cycle from the held row.
            acc_pkt_in  = acc_pkt_ff + ctr_q_ff[wcnt_ff].pkts_cnt;
            acc_byte_in = acc_byte_ff + ctr_q_ff[wcnt_ff].bytes_cnt;
            wcnt_in     = wcnt_ff + WR_W'(1);
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = '0;
               rsp_tdata_in[RSP_GRANT_LSB +: SLOT_FIELD_W] = res_granted_ff;
               rsp_tdata_in[RSP_PTOT_LSB +: TOTAL_W]       = acc_pkt_ff;
               rsp_tdata_in[RSP_BTOT_LSB +: TOTAL_W]       = acc_byte_ff;
               rsp_tdata_in[RSP_STATUS_LSB +: STATUS_W]    = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      slot_ff        <= slot_in;
      lane_ff        <= lane_in;
      pinc_ff        <= pinc_in;
      binc_ff        <= binc_in;
      wcnt_ff        <= wcnt_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      acc_pkt_ff     <= acc_pkt_in;
      acc_byte_ff    <= acc_byte_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   // Counter memory with a write enable per writer and a registered read.
   always_ff @(posedge clock) begin
      for (int w = 0; w < NUM_WRITERS; w++) begin
         if (ctr_wr_en[w]) begin
            ctr_mem[ctr_wr_addr][w] <= ctr_wr_data;
         end
      end
      if (ctr_rd_en) begin
         ctr_q_ff <= ctr_mem[ctr_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* src/fcse_checker.sv */
// Port-level checker for the flow counter slot engine, bound to the top level.
// Depends on fcse_pkg and flow_counter_slot_engine.
module fcse_checker
   import fcse_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [KIND_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A result word waiting for the sink holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // An error status comes with no granted slot and zero totals.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[RSP_STATUS_LSB +: STATUS_W] != STATUS_OK)
      |-> (rsp_tdata[RSP_STATUS_LSB-1:0] == '0))
      else $error("error status with nonzero result fields");

   // Only one item is in work: no request is taken right after another.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // The counter clearing pass keeps the request side closed after reset.
   a_clear_pass: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("request side open during clearing pass");

endmodule

bind flow_counter_slot_engine fcse_checker u_fcse_checker (.*);

/* bench/tb_flow_counter_slot_engine.sv */
// Testbench for the flow counter slot engine: request words are driven from a queue,
// and every result word is checked against a predictor of the slot stack and counters.
// Depends on fcse_pkg and flow_counter_slot_engine; needs no files or arguments.
`timescale 1ns / 1ps

module tb_flow_counter_slot_engine;
   import fcse_pkg::*;

   localparam int NUM_SLOTS     = DEF_NUM_SLOTS;
   localparam int NUM_WRITERS   = DEF_NUM_WRITERS;
   localparam int RANDOM_OPS    = 790;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLDOFF_AFTER = 150;
   localparam int HOLDOFF_LEN   = 400;
   localparam int SETTLE_CYCLES = 16;

   // One request word, split into its fields.
   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic [SLOT_FIELD_W-1:0]   slot;
      logic [WRITER_FIELD_W-1:0] writer;
      logic [PINC_W-1:0]         pkt_inc;
      logic [BINC_W-1:0]         byte_inc;
   } counter_op_type;

   // One result word, split into its fields.
   typedef struct {
      logic [SLOT_FIELD_W-1:0] granted;
      logic [TOTAL_W-1:0]      pkt_total;
      logic [TOTAL_W-1:0]      byte_total;
      logic [STATUS_W-1:0]     status;
   } counter_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   flow_counter_slot_engine #(
      .NUM_SLOTS   (NUM_SLOTS),
      .NUM_WRITERS (NUM_WRITERS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the free-slot stack and the counter table.
   logic [SLOT_FIELD_W-1:0] shadow_free_stack [NUM_SLOTS];
   int unsigned             shadow_free_count;
   logic [TOTAL_W-1:0]      shadow_pkts  [NUM_SLOTS*NUM_WRITERS];
   logic [TOTAL_W-1:0]      shadow_bytes [NUM_SLOTS*NUM_WRITERS];

   counter_op_type    queued_ops [$];
   counter_reply_type awaited_replies [$];
   int                words_queued = 0;
   int                words_accepted = 0;
   int                error_count = 0;
   int                cycle_count = 0;
   logic              word_taken = 1'b0;

   // Sender burst state and receiver stall state.
   int   burst_left = 0;
   int   gap_left = 0;
   int   run_left = 0;
   logic ready_phase = 1'b0;
   int   holdoff_left = 0;
   logic holdoff_done = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Zero every writer's pair of one slot.
   function automatic void zero_slot_counters(logic [SLOT_FIELD_W-1:0] slot);
      int w;
      for (w = 0; w < NUM_WRITERS; w++) begin
         shadow_pkts[int'(slot) * NUM_WRITERS + w]  = '0;
         shadow_bytes[int'(slot) * NUM_WRITERS + w] = '0;
      end
   endfunction

   // Apply one accepted operation to the shadow state and return its result.
   function automatic counter_reply_type predict_counter_op(counter_op_type op);
      counter_reply_type       r;
      int                      row;
      int                      w;
      logic                    slot_ok;
      logic [SLOT_FIELD_W-1:0] top_slot;
      r = '{default: '0};
      row = int'(op.slot) * NUM_WRITERS;
      slot_ok = int'(op.slot) < NUM_SLOTS;
      case (op.kind)
         KIND_ALLOC: begin
            if (shadow_free_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               shadow_free_count--;
               top_slot = shadow_free_stack[shadow_free_count % NUM_SLOTS];
               zero_slot_counters(top_slot);
               r.granted = top_slot;
            end
         end
         KIND_FREE: begin
            if (shadow_free_count >= NUM_SLOTS) begin
               r.status = STATUS_FULL;
            end else if (slot_ok) begin
               // A slot that is already free is pushed again without a check.
               shadow_free_stack[shadow_free_count] = op.slot;
               shadow_free_count++;
            end
         end
         KIND_INC: begin
            if (slot_ok && int'(op.writer) < NUM_WRITERS) begin
               shadow_pkts[row + int'(op.writer)]  += TOTAL_W'(op.pkt_inc);
               shadow_bytes[row + int'(op.writer)] += TOTAL_W'(op.byte_inc);
            end
         end
         KIND_GET: begin
            if (slot_ok) begin
               for (w = 0; w < NUM_WRITERS; w++) begin
                  r.pkt_total  += shadow_pkts[row + w];
                  r.byte_total += shadow_bytes[row + w];
               end
            end
         end
         KIND_CLEAR: begin
            if (slot_ok) zero_slot_counters(op.slot);
         end
         default: begin
            // Undefined kinds change nothing and return an all-zero word.
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, logic [TOTAL_W-1:0] want,
                                       logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $display("time %0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Mostly low-numbered slots, which sit at the top of the stack and allocate hands out first.
   function automatic logic [SLOT_FIELD_W-1:0] pick_slot();
      if ($urandom_range(0, 7) == 0) return SLOT_FIELD_W'($urandom_range(0, NUM_SLOTS - 1));
      return SLOT_FIELD_W'($urandom_range(0, 23));
   endfunction

   task automatic queue_op(kind_type kind, logic [SLOT_FIELD_W-1:0] slot,
                           logic [WRITER_FIELD_W-1:0] writer, logic [PINC_W-1:0] pkt_inc,
                           logic [BINC_W-1:0] byte_inc);
      counter_op_type op;
      op.kind     = kind;
      op.slot     = slot;
      op.writer   = writer;
      op.pkt_inc  = pkt_inc;
      op.byte_inc = byte_inc;
      queued_ops.push_back(op);
      words_queued++;
   endtask

   // Wait until every queued word is taken and every result has come back.
   task automatic wait_for_quiet();
      while (words_accepted != words_queued || awaited_replies.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: bursts of words with random gaps, holding each word until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || word_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (queued_ops.size() > 0) begin
            counter_op_type op;
            op = queued_ops.pop_front();
            req_tdata  <= {2'b00, op.byte_inc, op.pkt_inc, op.writer, op.slot};
            req_tuser  <= op.kind;
            req_tvalid <= 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(1, 12);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: alternating ready and stall runs, plus one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else if (!holdoff_done && words_accepted >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_LEN;
         rsp_tready <= 1'b0;
      end else begin
         if (run_left == 0) begin
            ready_phase = !ready_phase;
            run_left = ready_phase ? $urandom_range(1, 20) : $urandom_range(1, 6);
            if (ready_phase && $urandom_range(0, 4) == 0) run_left = 60;
         end
         run_left--;
         rsp_tready <= ready_phase;
      end
   end

   // Monitor: predict on each accepted request word, check each accepted result word.
   always @(posedge clock) begin
      counter_op_type    op;
      counter_reply_type want;
      word_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         op.slot     = req_tdata[REQ_SLOT_LSB +: SLOT_FIELD_W];
         op.writer   = req_tdata[REQ_WRITER_LSB +: WRITER_FIELD_W];
         op.pkt_inc  = req_tdata[REQ_PINC_LSB +: PINC_W];
         op.byte_inc = req_tdata[REQ_BINC_LSB +: BINC_W];
         op.kind     = req_tuser;
         awaited_replies.push_back(predict_counter_op(op));
         words_accepted++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            $display("time %0t: result word with none expected, expected nothing, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = awaited_replies.pop_front();
            check_field("granted_slot", TOTAL_W'(want.granted),
                        TOTAL_W'(rsp_tdata[RSP_GRANT_LSB +: SLOT_FIELD_W]));
            check_field("packet_total", want.pkt_total, rsp_tdata[RSP_PTOT_LSB +: TOTAL_W]);
            check_field("byte_total", want.byte_total, rsp_tdata[RSP_BTOT_LSB +: TOTAL_W]);
            check_field("status", TOTAL_W'(want.status),
                        TOTAL_W'(rsp_tdata[RSP_STATUS_LSB +: STATUS_W]));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Stimulus: directed words, random flows, then a pause and a short mixed tail.
   initial begin
      int                      i;
      int                      n;
      int                      random_count;
      kind_type                op_kind;
      logic [SLOT_FIELD_W-1:0] s;

      for (i = 0; i < NUM_SLOTS; i++) shadow_free_stack[i] = SLOT_FIELD_W'(NUM_SLOTS - 1 - i);
      shadow_free_count = NUM_SLOTS;
      for (i = 0; i < NUM_SLOTS * NUM_WRITERS; i++) begin
         shadow_pkts[i]  = '0;
         shadow_bytes[i] = '0;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Free into the full stack after reset, then fill slot 0 from every writer.
      queue_op(KIND_FREE, 12'd7, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_GET, 12'd0, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_ALLOC, 12'hFFF, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      queue_op(KIND_INC, 12'd0, 2'd0, 16'hFFFF, 32'hFFFF_FFFF);
      queue_op(KIND_INC, 12'd0, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      queue_op(KIND_INC, 12'd0, 2'd1, 16'd1, 32'd1);
      queue_op(KIND_INC, 12'd0, 2'd2, 16'd0, 32'd0);
      queue_op(KIND_GET, 12'd0, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      // The highest-numbered slot is counted even though it was never handed out.
      queue_op(KIND_INC, 12'hFFF, 2'd3, 16'h8000, 32'h8000_0000);
      queue_op(KIND_GET, 12'hFFF, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_CLEAR, 12'd0, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_GET, 12'd0, 2'd0, 16'd0, 32'd0);
      // Freeing the same slot twice puts it on the stack twice.
      queue_op(KIND_ALLOC, 12'd0, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_FREE, 12'd1, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_FREE, 12'd1, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_FREE, 12'd9, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_ALLOC, 12'd0, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_ALLOC, 12'd0, 2'd0, 16'd0, 32'd0);
      // Undefined kinds with every field bit set.
      queue_op(kind_type'(3'd5), 12'hFFF, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      queue_op(kind_type'(3'd6), 12'hFFF, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      queue_op(kind_type'(3'd7), 12'hFFF, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      queue_op(KIND_CLEAR, 12'hFFF, 2'd0, 16'd0, 32'd0);
      queue_op(KIND_GET, 12'hFFF, 2'd0, 16'd0, 32'd0);

      // Random part: mostly allocate, count, read back, release; the rest is noise.
      random_count = 0;
      while (random_count < RANDOM_OPS) begin
         if ($urandom_range(0, 9) < 7) begin
            s = pick_slot();
            queue_op(KIND_ALLOC, SLOT_FIELD_W'($urandom), WRITER_FIELD_W'($urandom),
                     PINC_W'($urandom), BINC_W'($urandom));
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
               queue_op(KIND_INC, s, WRITER_FIELD_W'($urandom),
                        ($urandom_range(0, 5) == 0) ? 16'hFFFF : PINC_W'($urandom),
                        ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : BINC_W'($urandom));
            queue_op(KIND_GET, s, WRITER_FIELD_W'($urandom), 16'd0, 32'd0);
            random_count += n + 2;
            case ($urandom_range(0, 3))
               0: queue_op(KIND_CLEAR, s, 2'd0, 16'd0, 32'd0);
               1, 2: queue_op(KIND_FREE, s, 2'd0, 16'd0, 32'd0);
               default: queue_op(KIND_GET, s, 2'd0, 16'd0, 32'd0);
            endcase
            random_count++;
         end else begin
            op_kind = kind_type'($urandom_range(0, 7));
            queue_op(op_kind, SLOT_FIELD_W'($urandom), WRITER_FIELD_W'($urandom),
                     PINC_W'($urandom), BINC_W'($urandom));
            random_count++;
         end
      end

      // Pause the sender until the block is empty, then mix frees and reuse.
      wait_for_quiet();
      for (i = 0; i < 40; i++)
         queue_op(kind_type'($urandom_range(0, 4)), pick_slot(), WRITER_FIELD_W'($urandom),
                  PINC_W'($urandom), BINC_W'($urandom));

      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && awaited_replies.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
